// File: src/bq_pkg.sv
// ----------------------------------------------------------------------------
// bq_pkg
// Shared types and constants for the transposed direct form II biquad section.
// ----------------------------------------------------------------------------
package bq_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int STATE_W    = 64;
	localparam int SHIFT_W    = 5;
	localparam int SHAMT_W    = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int SHIFT_MAX  = 28;
	localparam int BASE_SHIFT = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_B0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_B1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_B2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_A1  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_A2  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SHN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SHD = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MB0,
		ST_MB1,
		ST_MB2,
		ST_MA1,
		ST_MA2,
		ST_FIN
	} bq_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_B0,
		OP_B1,
		OP_B2,
		OP_A1,
		OP_A2,
		OP_FIN
	} bq_op_t;

	typedef struct packed {
		logic   load;
		bq_op_t op;
	} bq_cmd_t;

endpackage

// File: src/bq_ctrl.sv
// ----------------------------------------------------------------------------
// bq_ctrl
// Sequencer for one sample: five multiplies on the shared multiplier, then
// the state update and the output register load.
// ----------------------------------------------------------------------------
module bq_ctrl
	import bq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output logic    cfg_ready,
	output bq_cmd_t cmd
);

	bq_state_t state_q;
	bq_state_t state_nxt;
	logic      out_valid_q;
	logic      out_free;
	logic      finish;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd.op    = OP_NONE;
		in_stall  = 1'b1;
		finish    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nxt = ST_MB0;
				end
			end
			ST_MB0: begin
				cmd.op    = OP_B0;
				state_nxt = ST_MB1;
			end
			ST_MB1: begin
				cmd.op    = OP_B1;
				state_nxt = ST_MB2;
			end
			ST_MB2: begin
				cmd.op    = OP_B2;
				state_nxt = ST_MA1;
			end
			ST_MA1: begin
				cmd.op    = OP_A1;
				state_nxt = ST_MA2;
			end
			ST_MA2: begin
				cmd.op    = OP_A2;
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.op    = OP_FIN;
					finish    = 1'b1;
					in_stall  = 1'b0;
					state_nxt = in_valid ? ST_MB0 : ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
		cmd.load = in_valid && !in_stall;
	end

	assign out_valid = out_valid_q;
	assign cfg_ready = (state_q == ST_IDLE);

	// input transfers only when the datapath is free
	a_accept_state: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (state_q == ST_IDLE || state_q == ST_FIN))
		else $error("input transfer outside idle or final step");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_MB0))
		else $error("accepted sample did not start the multiply sequence");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
		else $error("result presented without finishing a sample");

	a_feedback_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MA1) |-> ($past(state_q) == ST_MB2))
		else $error("feedback multiply started before output was formed");

endmodule

// File: src/bq_dp.sv
// ----------------------------------------------------------------------------
// bq_dp
// Datapath: coefficient registers, one shared 32x32 multiplier, product
// shifter, accumulators, delay state and the output register.
// ----------------------------------------------------------------------------
module bq_dp
	import bq_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  bq_cmd_t                    cmd,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [SAMPLE_W-1:0]        cfg_data,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       end_of_block,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic                       end_of_block_out
);

	logic signed [SAMPLE_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [SHIFT_W-1:0]         shn_q, shd_q;
	logic [SHIFT_W-1:0]         cfg_shift;

	logic signed [SAMPLE_W-1:0] x_q;
	logic                       eob_q;
	logic signed [SAMPLE_W-1:0] y_q;
	logic signed [STATE_W-1:0]  prod_q;
	logic signed [STATE_W-1:0]  acc_q;
	logic signed [STATE_W-1:0]  nf_q;
	logic signed [STATE_W-1:0]  ns_q;
	logic signed [STATE_W-1:0]  w1_q;
	logic signed [STATE_W-1:0]  w2_q;
	logic signed [SAMPLE_W-1:0] out_q;
	logic                       eob_out_q;

	logic [SHIFT_W-1:0]         m;
	logic [SHIFT_W-1:0]         d;
	logic                       den_big;
	logic [SHAMT_W-1:0]         sx, sy, sh_amt;
	logic [SHIFT_W-1:0]         rs;
	logic signed [STATE_W-1:0]  half;
	logic signed [STATE_W-1:0]  sh_prod;
	logic signed [STATE_W-1:0]  y_wide;
	logic signed [SAMPLE_W-1:0] y_sat;
	logic signed [SAMPLE_W-1:0] mul_a, mul_b;
	logic signed [STATE_W-1:0]  mul_p;

	// shift values above range clamp to the maximum
	assign cfg_shift = (cfg_data[SHIFT_W-1:0] > SHIFT_W'(SHIFT_MAX)) ?
		SHIFT_W'(SHIFT_MAX) : cfg_data[SHIFT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q  <= '0;
			b1_q  <= '0;
			b2_q  <= '0;
			a1_q  <= '0;
			a2_q  <= '0;
			shn_q <= '0;
			shd_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_B0:  b0_q  <= cfg_data;
				CFG_B1:  b1_q  <= cfg_data;
				CFG_B2:  b2_q  <= cfg_data;
				CFG_A1:  a1_q  <= cfg_data;
				CFG_A2:  a2_q  <= cfg_data;
				CFG_SHN: shn_q <= cfg_shift;
				CFG_SHD: shd_q <= cfg_shift;
				default: ;
			endcase
		end
	end

	// format alignment
	always_comb begin
		den_big = shd_q > shn_q;
		m       = den_big ? shd_q : shn_q;
		d       = den_big ? (shd_q - shn_q) : (shn_q - shd_q);
		sx      = den_big ? (SHAMT_W'(BASE_SHIFT) + SHAMT_W'(d)) : SHAMT_W'(BASE_SHIFT);
		sy      = den_big ? SHAMT_W'(BASE_SHIFT) : (SHAMT_W'(BASE_SHIFT) + SHAMT_W'(d));
		rs      = SHIFT_W'(SHIFT_MAX) - m;
		if (m <= SHIFT_W'(SHIFT_MAX - 1)) begin
			half = STATE_W'(1) << (SHIFT_W'(SHIFT_MAX - 1) - m);
		end else begin
			half = '0;
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = b0_q;
		mul_b = x_q;
		case (cmd.op)
			OP_B0: mul_a = b0_q;
			OP_B1: mul_a = b1_q;
			OP_B2: mul_a = b2_q;
			OP_A1: begin
				mul_a = a1_q;
				mul_b = y_q;
			end
			OP_A2: begin
				mul_a = a2_q;
				mul_b = y_q;
			end
			default: ;
		endcase
		mul_p = mul_a * mul_b;
	end

	// feedback products arrive in the last two steps
	assign sh_amt  = (cmd.op == OP_A2 || cmd.op == OP_FIN) ? sy : sx;
	assign sh_prod = prod_q >>> sh_amt;

	assign y_wide = acc_q >>> rs;
	always_comb begin
		if (&y_wide[STATE_W-1:SAMPLE_W-1] || ~|y_wide[STATE_W-1:SAMPLE_W-1]) begin
			y_sat = y_wide[SAMPLE_W-1:0];
		end else if (y_wide[STATE_W-1]) begin
			y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q   <= sample_in;
			eob_q <= end_of_block;
		end
		case (cmd.op)
			OP_B0: begin
				prod_q <= mul_p;
			end
			OP_B1: begin
				prod_q <= mul_p;
				acc_q  <= sh_prod + w1_q + half;
			end
			OP_B2: begin
				prod_q <= mul_p;
				nf_q   <= sh_prod + w2_q;
				y_q    <= y_sat;
			end
			OP_A1: begin
				prod_q <= mul_p;
				ns_q   <= sh_prod;
			end
			OP_A2: begin
				prod_q <= mul_p;
				nf_q   <= nf_q - sh_prod;
			end
			OP_FIN: begin
				out_q     <= y_q;
				eob_out_q <= eob_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w1_q <= '0;
			w2_q <= '0;
		end else if (cmd.op == OP_FIN) begin
			w1_q <= nf_q;
			w2_q <= ns_q - sh_prod;
		end
	end

	assign sample_out       = out_q;
	assign end_of_block_out = eob_out_q;

endmodule

// File: src/biquad_tdf2_32bit_64bit_state.sv
// ----------------------------------------------------------------------------
// biquad_tdf2_32bit_64bit_state
// One second-order IIR section in transposed direct form II with 32-bit
// samples and 64-bit delay state.
// ----------------------------------------------------------------------------
// Each sample runs through the steps MB0, MB1, MB2, MA1, MA2 and FIN: the
// five products b0*x, b1*x, b2*x, a1*y and a2*y are formed one per cycle on
// a single shared 32x32 multiplier, and the final step updates the delay
// state and loads the output register. A new sample is taken in that final
// step, so samples follow one another without an idle step as long as the
// previous result has been taken; a waiting result holds the block in its
// final step. Coefficients and shifts are written through the cfg port,
// which is ready only while no sample is in progress.
module biquad_tdf2_32bit_64bit_state
	import bq_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [SAMPLE_W-1:0]         cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [SAMPLE_W-1:0]  sample_in,
	input  logic                        end_of_block,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [SAMPLE_W-1:0]  sample_out,
	output logic                        end_of_block_out
);

	bq_cmd_t cmd;
	logic    cfg_we;

	assign cfg_we = cfg_valid && cfg_ready;

	bq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	bq_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.sample_in        (sample_in),
		.end_of_block     (end_of_block),
		.sample_out       (sample_out),
		.end_of_block_out (end_of_block_out)
	);

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 32-bit TDF-II biquad section. A software
// filter with its own 64-bit delay words predicts every output sample from
// the accepted inputs and the programmed coefficients; directed tests cover
// saturation, shift extremes and clamping, then randomized phases
// reprogram the filter and stream samples with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
	import bq_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [STATE_W-1:0] SAT_HI = 64'sd2147483647;
	localparam logic signed [STATE_W-1:0] SAT_LO = -64'sd2147483648;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES = 12;
	localparam int PHASE_LEN = 44;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       eob;
	} out_sample_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [SAMPLE_W-1:0]        cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic                       end_of_block = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       end_of_block_out;

	// filter copy
	logic signed [STATE_W-1:0] cur_b0 = '0, cur_b1 = '0, cur_b2 = '0;
	logic signed [STATE_W-1:0] cur_a1 = '0, cur_a2 = '0;
	logic [SHIFT_W-1:0]        cur_shn = '0, cur_shd = '0;
	logic signed [STATE_W-1:0] w1 = '0, w2 = '0;

	out_sample_t pending_out[$];
	out_sample_t want;
	int          errors = 0;
	int          stall_run = 0;
	int          stall_pct = 0;
	int          gap_pct = 0;
	bit          calm = 1'b0;
	int          idle_cycles = 0;

	biquad_tdf2_32bit_64bit_state i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample_in        (sample_in),
		.end_of_block     (end_of_block),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sample_out       (sample_out),
		.end_of_block_out (end_of_block_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [SHIFT_W-1:0] shift_limit(input logic [SAMPLE_W-1:0] data);
		logic [SHIFT_W-1:0] s;
		s = data[SHIFT_W-1:0];
		return (s > SHIFT_MAX) ? SHIFT_W'(SHIFT_MAX) : s;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [SAMPLE_W-1:0] data);
		case (idx)
			CFG_B0: cur_b0 = $signed(data);
			CFG_B1: cur_b1 = $signed(data);
			CFG_B2: cur_b2 = $signed(data);
			CFG_A1: cur_a1 = $signed(data);
			CFG_A2: cur_a2 = $signed(data);
			CFG_SHN: cur_shn = shift_limit(data);
			CFG_SHD: cur_shd = shift_limit(data);
			default: ;
		endcase
	endfunction

	// one sample through the section, updates the delay words
	function automatic logic signed [SAMPLE_W-1:0] filter_step(
			input logic signed [SAMPLE_W-1:0] x);
		int m, sx, sy;
		logic signed [STATE_W-1:0] xl, yl, half, acc, rnd, nf, ns;
		logic signed [SAMPLE_W-1:0] y;
		if (cur_shd > cur_shn) begin
			m = cur_shd;
			sx = BASE_SHIFT + cur_shd - cur_shn;
			sy = BASE_SHIFT;
		end else begin
			m = cur_shn;
			sx = BASE_SHIFT;
			sy = BASE_SHIFT + cur_shn - cur_shd;
		end
		half = (m <= SHIFT_MAX - 1) ? (64'sd1 <<< (SHIFT_MAX - 1 - m)) : 64'sd0;
		xl = x;
		acc = ((cur_b0 * xl) >>> sx) + w1;
		rnd = (acc + half) >>> (SHIFT_MAX - m);
		if (rnd > SAT_HI)
			y = S_MAX;
		else if (rnd < SAT_LO)
			y = S_MIN;
		else
			y = rnd[SAMPLE_W-1:0];
		yl = y;
		nf = ((cur_b1 * xl) >>> sx) - ((cur_a1 * yl) >>> sy) + w2;
		ns = ((cur_b2 * xl) >>> sx) - ((cur_a2 * yl) >>> sy);
		w1 = nf;
		w2 = ns;
		return y;
	endfunction

	function automatic void log_error(input string msg);
		if (errors < 10)
			$display("tb_top: %s", msg);
		errors++;
	endfunction

	// output check and receiver back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_out.size() == 0) begin
					log_error($sformatf("unexpected output sample %0d eob %0b",
						sample_out, end_of_block_out));
				end else begin
					want = pending_out.pop_front();
					if (sample_out !== want.sample || end_of_block_out !== want.eob)
						log_error($sformatf("expected sample %0d eob %0b, got sample %0d eob %0b",
							want.sample, want.eob, sample_out, end_of_block_out));
				end
			end
			if (stall_run > 0) begin
				out_stall <= 1'b1;
				stall_run--;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				stall_run = $urandom_range(1, 7) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic program_filter(input logic [SAMPLE_W-1:0] b0, b1, b2, a1, a2, shn, shd);
		cfg_write(CFG_B0, b0);
		cfg_write(CFG_B1, b1);
		cfg_write(CFG_B2, b2);
		cfg_write(CFG_A1, a1);
		cfg_write(CFG_A2, a2);
		cfg_write(CFG_SHN, shn);
		cfg_write(CFG_SHD, shd);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic eob);
		out_sample_t r;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7))
				@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= x;
		end_of_block <= eob;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r.sample = filter_step(x);
		r.eob = eob;
		pending_out.push_back(r);
	endtask

	// stop sending and wait for every predicted sample
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_coef();
		case ($urandom_range(0, 7))
			0: return S_MIN;
			1: return S_MAX;
			2, 3: return $urandom;
			default: return $signed($urandom) >>> $urandom_range(2, 14);
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 11))
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			3: return -32'sd1;
			4, 5, 6: return $signed($urandom) >>> $urandom_range(1, 24);
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_shift(input int pick);
		logic [SAMPLE_W-1:0] s;
		case (pick)
			0: s = 0;
			1: s = SHIFT_MAX;
			2: s = $urandom_range(SHIFT_MAX + 1, 31);
			default: s = $urandom_range(0, SHIFT_MAX);
		endcase
		if ($urandom_range(0, 3) == 0)
			s = ($urandom & ~32'h1f) | s;
		return s;
	endfunction

	task automatic test_reset_state;
		send_sample(S_MAX, 1'b1);
		send_sample(S_MIN, 1'b0);
		drain();
	endtask

	task automatic test_saturation;
		program_filter(S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, 28, 0);
		send_sample(S_MIN, 1'b0);
		send_sample(S_MAX, 1'b1);
		send_sample(-32'sd1, 1'b0);
		send_sample(32'sd1, 1'b1);
		send_sample('0, 1'b0);
		drain();
	endtask

	task automatic test_den_shift;
		program_filter(S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, 0, 28);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b1);
		send_sample(32'sd12345, 1'b0);
		send_sample(-32'sd1, 1'b1);
		drain();
	endtask

	task automatic test_shift_clamp;
		// 31 and 29 in the low bits with junk above, both read as 28
		program_filter(32'h0800_0000, 32'hf800_0000, 32'h0400_0000, 32'h1000_0000,
			32'hfc00_0000, 32'hffff_ffff, 32'h1234_567d);
		send_sample(S_MAX, 1'b1);
		send_sample(S_MIN, 1'b0);
		send_sample(32'sd7, 1'b1);
		drain();
	endtask

	task automatic test_round_edge;
		// m of 27 adds one lsb before the shift, 28 adds none
		program_filter(32'h0800_0001, 32'h0000_0003, 32'hffff_fffd, 32'h0000_0005,
			32'hffff_fffb, 27, 27);
		send_sample(32'sd1, 1'b0);
		send_sample(-32'sd1, 1'b1);
		drain();
	endtask

	task automatic test_spare_index;
		cfg_write(CFG_SPARE, $urandom);
		cfg_valid <= 1'b0;
		send_sample(32'sd1000, 1'b0);
		send_sample(-32'sd1000, 1'b1);
		drain();
	endtask

	task automatic test_random_phases;
		int pn, pd;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin pn = 0; pd = 1; end
				1: begin pn = 1; pd = 0; end
				2: begin pn = 2; pd = 2; end
				default: begin pn = $urandom_range(0, 5); pd = $urandom_range(0, 5); end
			endcase
			program_filter(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
				rand_shift(pn), rand_shift(pd));
			case ($urandom_range(0, 2))
				0: begin stall_pct = 0; gap_pct = 0; end
				1: begin stall_pct = 15; gap_pct = 15; end
				default: begin stall_pct = 40; gap_pct = 40; end
			endcase
			if (p == PHASES - 1)
				calm = 1'b1;
			for (int i = 0; i < PHASE_LEN; i++) begin
				send_sample(rand_sample(), 1'($urandom_range(0, 1)));
				if (p == 5 && i == PHASE_LEN / 2)
					drain();
			end
			drain();
		end
	endtask

	initial begin
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_saturation();
		test_den_shift();
		test_shift_clamp();
		test_round_edge();
		test_spare_index();
		test_random_phases();
		drain();
		repeat (20)
			@(posedge clk);
		errors += pending_out.size();
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
